@@ hdl/bcfs_pkg.sv @@
// bcfs_pkg: shared types, constants and codes of the bracket command frame splitter
// depends on nothing; every other file imports it
`timescale 1ns / 1ps

package bcfs_pkg;

  // fixed field widths
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 8;
  localparam int LEN_W   = 8;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 4;

  // defaults for top level parameters
  localparam int DEF_MAX_COMMANDS = 8;
  localparam int DEF_INDEX_BITS   = 8;

  // token queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  // configuration reset and length saturation
  localparam logic [LEN_W-1:0] MIN_LEN_RESET = 8'd4;
  localparam logic [LEN_W-1:0] LEN_MAX       = 8'hFF;

  // characters of interest
  localparam logic [BYTE_W-1:0] CH_OPEN_SQ  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_OPEN_RD  = 8'h28;
  localparam logic [BYTE_W-1:0] CH_CLOSE_SQ = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_CLOSE_RD = 8'h29;
  localparam logic [BYTE_W-1:0] CH_SEMI     = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_DIG_LO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_DIG_HI   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UPR_LO   = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPR_HI   = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LWR_LO   = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LWR_HI   = 8'h7A;

  // frame kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd2;

  typedef enum logic [2:0] {
    CLS_OPEN_SQ,
    CLS_OPEN_RD,
    CLS_CLOSE_SQ,
    CLS_CLOSE_RD,
    CLS_SEMI,
    CLS_ALNUM,
    CLS_OTHER
  } tok_class_e;

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_FRAME,
    PH_OVER,
    PH_CLOSED
  } parse_phase_e;

  typedef enum logic {
    BS_PARSE,
    BS_EMIT
  } back_state_e;

  // classified byte handed from front to back
  typedef struct packed {
    logic [POS_W-1:0] next_pos;
    tok_class_e       cls;
    logic             eob;
  } token_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // one kept command
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
  } cmd_entry_t;

endpackage

@@ hdl/bcfs_if.sv @@
// bcfs_in_if and bcfs_out_if: valid/ready channels for input bytes and result records
// depends on bcfs_pkg
`timescale 1ns / 1ps

interface bcfs_in_if
  import bcfs_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface bcfs_out_if
  import bcfs_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  frame_kind;
  logic [COUNT_W-1:0] command_count;
  logic [POS_W-1:0]   command_position;
  logic [LEN_W-1:0]   command_length;
  logic               entry_valid;
  logic               last_of_run;

  modport source (output valid, output frame_kind, output command_count,
                  output command_position, output command_length,
                  output entry_valid, output last_of_run, input ready);
  modport sink   (input valid, input frame_kind, input command_count,
                  input command_position, input command_length,
                  input entry_valid, input last_of_run, output ready);
endinterface

@@ hdl/bcfs_front.sv @@
// bcfs_front: accepts input bytes, numbers them and classifies each into a token
// depends on bcfs_pkg and bcfs_in_if
`timescale 1ns / 1ps

module bcfs_front
  import bcfs_pkg::*;
#(
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bcfs_in_if.sink      in_i,
  input  logic         full_i,
  output logic         push_o,
  output token_t       tok_o
);

  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic [INDEX_BITS-1:0] next_idx;

  function automatic tok_class_e classify(input logic [BYTE_W-1:0] b);
    tok_class_e c;
    case (b) inside
      CH_OPEN_SQ:                                                  c = CLS_OPEN_SQ;
      CH_OPEN_RD:                                                  c = CLS_OPEN_RD;
      CH_CLOSE_SQ:                                                 c = CLS_CLOSE_SQ;
      CH_CLOSE_RD:                                                 c = CLS_CLOSE_RD;
      CH_SEMI:                                                     c = CLS_SEMI;
      [CH_DIG_LO:CH_DIG_HI], [CH_UPR_LO:CH_UPR_HI], [CH_LWR_LO:CH_LWR_HI]: c = CLS_ALNUM;
      default:                                                     c = CLS_OTHER;
    endcase
    return c;
  endfunction

  // handshake toward the queue
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // position of the byte after this one, wrapping
  assign next_idx = idx_q + 1'b1;

  // token payload
  always_comb begin
    tok_o.next_pos = POS_W'(next_idx);
    tok_o.cls      = classify(in_i.data_byte);
    tok_o.eob      = in_i.end_of_buffer;
  end

  // byte counter restarts after the final byte of a buffer
  always_comb begin
    idx_d = idx_q;
    if (push_o) begin
      idx_d = in_i.end_of_buffer ? '0 : next_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

@@ hdl/bcfs_fifo.sv @@
// bcfs_fifo: short token queue that decouples the front from the back
// depends on bcfs_pkg
`timescale 1ns / 1ps

module bcfs_fifo
  import bcfs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  token_t        push_data_i,
  input  logic          pop_i,
  output token_t        pop_data_o,
  output queue_status_t status_o
);

  token_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W:0]   wr_ptr_q, rd_ptr_q;

  // status from the pointers, extra bit tells full from empty
  always_comb begin
    status_o.empty = (wr_ptr_q == rd_ptr_q);
    status_o.full  = (wr_ptr_q[FIFO_PTR_W] != rd_ptr_q[FIFO_PTR_W]) &&
                     (wr_ptr_q[FIFO_PTR_W-1:0] == rd_ptr_q[FIFO_PTR_W-1:0]);
  end

  assign pop_data_o = mem_q[rd_ptr_q[FIFO_PTR_W-1:0]];

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q[FIFO_PTR_W-1:0]] <= push_data_i;
    end
  end

endmodule

@@ hdl/bcfs_back.sv @@
// bcfs_back: frame parser, command table and record emitter with output register
// depends on bcfs_pkg and bcfs_out_if
`timescale 1ns / 1ps

module bcfs_back
  import bcfs_pkg::*;
#(
  parameter int MAX_COMMANDS = DEF_MAX_COMMANDS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  input  logic             tok_valid_i,
  input  token_t           tok_i,
  output logic             pop_o,
  bcfs_out_if.source       out_o
);

  localparam int CNT_W = $clog2(MAX_COMMANDS + 1);
  localparam int IDX_W = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COMMANDS);

  back_state_e       state_q, state_d;
  parse_phase_e      phase_q, phase_d;
  logic [LEN_W-1:0]  min_len_q;
  logic              closing_q, closing_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              clean_q, clean_d;
  logic [POS_W-1:0]  start_q, start_d;
  logic [CNT_W-1:0]  kept_q, kept_d;
  logic [CNT_W-1:0]  kept_inc;
  logic [KIND_W-1:0] result_q, result_d;

  logic              emit_valid_q, emit_valid_d;
  logic [KIND_W-1:0] emit_kind_q, emit_kind_d;
  logic [CNT_W-1:0]  emit_cnt_q, emit_cnt_d;
  logic [IDX_W-1:0]  emit_idx_q, emit_idx_d;
  logic              emit_last;

  cmd_entry_t        table_q [MAX_COMMANDS];
  logic              tbl_we;
  logic              keep;
  tok_class_e        closer_cls;

  logic              out_valid_q, out_valid_d;
  logic              out_load;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RESET;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  // qualification of the command in progress
  assign keep       = (len_q >= min_len_q) && clean_q && (kept_q < CNT_MAX);
  assign kept_inc   = kept_q + 1'b1;
  assign closer_cls = closing_q ? CLS_CLOSE_RD : CLS_CLOSE_SQ;
  assign pop_o      = (state_q == BS_PARSE) && tok_valid_i;

  // emitter bookkeeping
  assign emit_last = !emit_valid_q ||
                     ((CNT_W'(emit_idx_q) + CNT_W'(1)) == emit_cnt_q);
  assign out_load  = (state_q == BS_EMIT) && (!out_valid_q || out_o.ready);

  // parser and emitter next state
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    closing_d    = closing_q;
    len_d        = len_q;
    clean_d      = clean_q;
    start_d      = start_q;
    kept_d       = kept_q;
    result_d     = result_q;
    emit_valid_d = emit_valid_q;
    emit_kind_d  = emit_kind_q;
    emit_cnt_d   = emit_cnt_q;
    emit_idx_d   = emit_idx_q;
    tbl_we       = 1'b0;

    if (pop_o) begin
      case (phase_q)
        PH_SEEK: begin
          len_d   = '0;
          kept_d  = '0;
          start_d = tok_i.next_pos;
          if (tok_i.cls == CLS_OPEN_SQ || tok_i.cls == CLS_OPEN_RD) begin
            closing_d = (tok_i.cls == CLS_OPEN_RD);
            clean_d   = 1'b1;
            phase_d   = PH_FRAME;
          end
        end
        PH_FRAME: begin
          if (tok_i.cls == CLS_SEMI) begin
            if (keep) begin
              tbl_we = 1'b1;
              kept_d = kept_inc;
              // table full at a separator invalidates the frame
              if (kept_inc >= CNT_MAX) begin
                result_d = KIND_NONE;
                phase_d  = PH_OVER;
              end
            end
            start_d = tok_i.next_pos;
            len_d   = '0;
            clean_d = 1'b1;
          end else if (tok_i.cls == closer_cls) begin
            if (keep) begin
              tbl_we = 1'b1;
              kept_d = kept_inc;
            end
            result_d = closing_q ? KIND_ROUND : KIND_SQUARE;
            phase_d  = PH_CLOSED;
          end else if (tok_i.cls == CLS_ALNUM) begin
            if (len_q != LEN_MAX) begin
              len_d = len_q + 1'b1;
            end
          end else begin
            clean_d = 1'b0;
          end
        end
        default: ;
      endcase

      // end of buffer: latch the run and restart the parser
      if (tok_i.eob) begin
        emit_valid_d = (result_d != KIND_NONE) && (kept_d != '0);
        emit_kind_d  = result_d;
        emit_cnt_d   = kept_d;
        emit_idx_d   = '0;
        state_d      = BS_EMIT;
        phase_d      = PH_SEEK;
        closing_d    = 1'b0;
        len_d        = '0;
        clean_d      = 1'b1;
        start_d      = '0;
        kept_d       = '0;
        result_d     = KIND_NONE;
      end
    end

    // one record per load
    if (out_load) begin
      if (emit_last) begin
        state_d    = BS_PARSE;
        emit_idx_d = '0;
      end else begin
        emit_idx_d = emit_idx_q + 1'b1;
      end
    end
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BS_PARSE;
      phase_q      <= PH_SEEK;
      closing_q    <= 1'b0;
      len_q        <= '0;
      clean_q      <= 1'b1;
      start_q      <= '0;
      kept_q       <= '0;
      result_q     <= KIND_NONE;
      emit_valid_q <= 1'b0;
      emit_kind_q  <= KIND_NONE;
      emit_cnt_q   <= '0;
      emit_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      closing_q    <= closing_d;
      len_q        <= len_d;
      clean_q      <= clean_d;
      start_q      <= start_d;
      kept_q       <= kept_d;
      result_q     <= result_d;
      emit_valid_q <= emit_valid_d;
      emit_kind_q  <= emit_kind_d;
      emit_cnt_q   <= emit_cnt_d;
      emit_idx_q   <= emit_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // command table, written at the slot of the next kept command
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      table_q[kept_q[IDX_W-1:0]] <= '{pos: start_q, len: len_q};
    end
  end

  // output record register, table read registered here
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.frame_kind       <= emit_kind_q;
      out_o.command_count    <= emit_valid_q ? COUNT_W'(emit_cnt_q) : '0;
      out_o.command_position <= emit_valid_q ? table_q[emit_idx_q].pos : '0;
      out_o.command_length   <= emit_valid_q ? table_q[emit_idx_q].len : '0;
      out_o.entry_valid      <= emit_valid_q;
      out_o.last_of_run      <= emit_last;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

@@ hdl/bracket_command_frame_splitter_unit.sv @@
// bracket_command_frame_splitter_unit: top level of the bracket command frame splitter
// one byte per cycle while the token queue is not full; once the final byte has passed the
// queue and the back, the back loads 1 to MAX_COMMANDS records into its output register at
// the end of a buffer; the four-entry token queue takes bytes meanwhile, then input stalls
// reset is asynchronous, active low: parser idle, minimum length 4, command table not cleared
// depends on bcfs_pkg, bcfs_if, bcfs_front, bcfs_fifo, bcfs_back
`timescale 1ns / 1ps

module bracket_command_frame_splitter_unit
  import bcfs_pkg::*;
#(
  parameter int MAX_COMMANDS = DEF_MAX_COMMANDS,
  parameter int INDEX_BITS   = DEF_INDEX_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  bcfs_in_if.sink          in_i,
  bcfs_out_if.source       out_o
);

  logic          push;
  logic          pop;
  token_t        push_tok;
  token_t        pop_tok;
  queue_status_t qstat;

  // front: accept and classify
  bcfs_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (qstat.full),
    .push_o (push),
    .tok_o  (push_tok)
  );

  // token queue
  bcfs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_tok),
    .pop_i       (pop),
    .pop_data_o  (pop_tok),
    .status_o    (qstat)
  );

  // back: parse, store and emit
  bcfs_back #(
    .MAX_COMMANDS (MAX_COMMANDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tok_valid_i (!qstat.empty),
    .tok_i       (pop_tok),
    .pop_o       (pop),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // queue never written while full
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !qstat.full)
    else $error("token pushed into a full queue");

  // queue never read while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !qstat.empty)
    else $error("token popped from an empty queue");

  // a record that is not a command ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.entry_valid) |-> out_o.last_of_run)
    else $error("invalid record not marked last");

  // a kept command belongs to a closed frame with a nonzero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.entry_valid) |->
      (out_o.frame_kind != KIND_NONE && out_o.command_count != 0))
    else $error("command record without frame kind or count");
`endif

endmodule
